// ===== rtl/core/bqbe_pkg.sv =====
package bqbe_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int FX_W          = 32;
  localparam int PAR_W         = 17;
  localparam int ACC_W         = FX_W + 4;
  localparam int DIV_W         = FX_W + FRACTION_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
  localparam int IN_W          = 296;
  localparam int OUT_W         = 288;
  localparam int USER_W        = 3;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [2*FX_W-1:0] wide_t;

  localparam fx_t   FX_MAX  = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t   FX_MIN  = {1'b1, {(FX_W-1){1'b0}}};
  localparam fx_t   FX_ONE  = fx_t'(64'sd1 << FRACTION_BITS);
  localparam wide_t FX_HALF = wide_t'(64'sd1 << (FRACTION_BITS - 1));

  // Sequencer landmarks of the back end
  localparam logic [5:0] STEP_JAC_FIRST = 6'd4;
  localparam logic [5:0] STEP_JAC_LAST  = 6'd19;
  localparam logic [5:0] STEP_DET       = 6'd21;
  localparam logic [5:0] STEP_LAST      = 6'd38;
  localparam logic [2:0] DIV_LAST_INV   = 3'd3;
  localparam logic [2:0] DIV_LAST       = 3'd6;
  localparam logic [3:0] SUB_LAST       = 4'd8;
  localparam logic [1:0] NODE_LAST      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_NODE,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    fx_t [3:0] x;
    fx_t [3:0] y;
    fx_t       r;
    fx_t       s;
    fx_t       omr;
    fx_t       oms;
    fx_t [3:0] dr;
    fx_t [3:0] ds;
    fx_t       xrs;
    fx_t       yrs;
  } item_t;

  typedef struct packed {
    fx_t [3:0] nval;
    fx_t [3:0] ddx;
    fx_t [3:0] ddy;
    fx_t [3:0] dxx;
    fx_t [3:0] dyy;
    fx_t [3:0] dxy;
    fx_t [3:0] jac;
    fx_t [3:0] inv;
    fx_t       det;
    logic      degen;
  } res_t;

  typedef struct packed {
    logic start;
    fx_t  num;
    fx_t  den;
  } div_req_t;

  typedef struct packed {
    logic done;
    fx_t  quo;
  } div_rsp_t;

  function automatic fx_t sat_w(wide_t v);
    if (v > wide_t'(FX_MAX)) return FX_MAX;
    if (v < wide_t'(FX_MIN)) return FX_MIN;
    return fx_t'(v);
  endfunction

  // Exact product, round half up, saturate
  function automatic fx_t fmul(fx_t a, fx_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b) + FX_HALF;
    return sat_w(p >>> FRACTION_BITS);
  endfunction

  function automatic fx_t neg_sat(fx_t a);
    return (a == FX_MIN) ? FX_MAX : -a;
  endfunction

endpackage

// ===== rtl/core/bqbe_front.sv =====
module bqbe_front import bqbe_pkg::*; (
  input  logic            s_tvalid,
  output logic            s_tready,
  // node_x0..3, node_y0..3 (32 each), point_r (17), point_s (17), zero pad
  input  logic [IN_W-1:0] s_tdata,
  input  logic            q_full,
  output logic            q_push,
  output item_t           q_item
);

  logic [PAR_W-1:0] r_raw, s_raw;
  fx_t              r_fx, s_fx, r_c, s_c;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    r_raw = s_tdata[8*FX_W +: PAR_W];
    s_raw = s_tdata[8*FX_W+PAR_W +: PAR_W];
    r_fx  = fx_t'(r_raw);
    s_fx  = fx_t'(s_raw);
    // clamp the parametric point into [0,1]
    r_c   = (r_fx > FX_ONE) ? FX_ONE : r_fx;
    s_c   = (s_fx > FX_ONE) ? FX_ONE : s_fx;
    for (int i = 0; i < 4; i++) begin
      q_item.x[i] = s_tdata[FX_W*i +: FX_W];
      q_item.y[i] = s_tdata[FX_W*(4+i) +: FX_W];
    end
    q_item.r   = r_c;
    q_item.s   = s_c;
    q_item.omr = FX_ONE - r_c;
    q_item.oms = FX_ONE - s_c;
    q_item.dr[0] = s_c - FX_ONE;
    q_item.dr[1] = FX_ONE - s_c;
    q_item.dr[2] = s_c;
    q_item.dr[3] = -s_c;
    q_item.ds[0] = r_c - FX_ONE;
    q_item.ds[1] = -r_c;
    q_item.ds[2] = r_c;
    q_item.ds[3] = FX_ONE - r_c;
    q_item.xrs = sat_w(wide_t'(q_item.x[0]) - wide_t'(q_item.x[1])
                     + wide_t'(q_item.x[2]) - wide_t'(q_item.x[3]));
    q_item.yrs = sat_w(wide_t'(q_item.y[0]) - wide_t'(q_item.y[1])
                     + wide_t'(q_item.y[2]) - wide_t'(q_item.y[3]));
  end

endmodule

// ===== rtl/core/bqbe_fifo.sv =====
module bqbe_fifo import bqbe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  not_empty
);

  item_t      slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

endmodule

// ===== rtl/core/bqbe_div.sv =====
module bqbe_div import bqbe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy, fin, neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FX_W-1:0]      rem, dsr, num_mag, den_mag;
  logic [DIV_W-1:0]     dvd;
  logic [FX_W:0]        trial;

  always_comb begin
    num_mag = req.num[FX_W-1] ? FX_W'(-req.num) : FX_W'(req.num);
    den_mag = req.den[FX_W-1] ? FX_W'(-req.den) : FX_W'(req.den);
    trial   = {rem, dvd[DIV_W-1]};
  end

  // restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          rsp.done <= 1'b1;
          rsp.quo  <= '0;
        end else begin
          dvd  <= DIV_W'(num_mag) << FRACTION_BITS;
          dsr  <= den_mag;
          rem  <= '0;
          cnt  <= DIV_CNT_W'(DIV_W);
          neg  <= req.num[FX_W-1] ^ req.den[FX_W-1];
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= FX_W'(trial - {1'b0, dsr});
          dvd <= {dvd[DIV_W-2:0], 1'b1};
        end else begin
          rem <= FX_W'(trial);
          dvd <= {dvd[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin      <= 1'b0;
        rsp.done <= 1'b1;
        // apply sign, saturate to 32 bits
        if (neg) begin
          rsp.quo <= (dvd[DIV_W-1:FX_W-1] != '0) ? FX_MIN
                                                 : fx_t'(~{1'b0, dvd[FX_W-2:0]} + 1'b1);
        end else begin
          rsp.quo <= (dvd[DIV_W-1:FX_W-1] != '0) ? FX_MAX : fx_t'({1'b0, dvd[FX_W-2:0]});
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (!busy && !fin))
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("divider done held longer than one cycle");

endmodule

// ===== rtl/core/bqbe_back.sv =====
module bqbe_back import bqbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              m_tvalid,
  input  logic              m_tready,
  // shape_value, shape_dx, shape_dy, shape_dxx, shape_dyy, shape_dxy,
  // jacobian_entry, inverse_jacobian_entry, jacobian_det (32 each)
  output logic [OUT_W-1:0]  m_tdata,
  // node_index (2), degenerate (1)
  output logic [USER_W-1:0] m_tuser,
  output logic              m_tlast
);

  back_state_t state, state_next;
  item_t       cur;
  logic [5:0]  step, jstep;
  logic [2:0]  div_sel;
  logic        div_wait;
  logic [1:0]  k;
  logic [3:0]  sub;
  fx_t [3:0]   nval, jac, inv, ddx, ddy, dxx, dyy, dxy;
  fx_t [2:0]   cof, q;
  fx_t         t03, det, det_cand, detA;
  fx_t         a11, a12, a13, a21, a22, a23, a31, a32, a33;
  fx_t         ddx_c, ddy_c, bval;
  acc_t        acc;
  logic        degen;
  fx_t         mul_a, mul_b, p;
  res_t        ob;
  logic        ob_valid;
  logic [1:0]  beat;

  assign jstep    = step - STEP_JAC_FIRST;
  assign p        = fmul(mul_a, mul_b);
  assign det_cand = sat_w(wide_t'(t03) - wide_t'(p));

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL: begin
        if (step < STEP_JAC_FIRST) begin
          mul_a = step[0] ? cur.r : cur.omr;
          mul_b = step[1] ? cur.s : cur.oms;
          if (step[1:0] == 2'd2) mul_a = cur.r;
          if (step[1:0] == 2'd3) mul_a = cur.omr;
        end else if (step <= STEP_JAC_LAST) begin
          mul_a = jstep[3] ? cur.y[jstep[1:0]] : cur.x[jstep[1:0]];
          mul_b = jstep[2] ? cur.ds[jstep[1:0]] : cur.dr[jstep[1:0]];
        end else begin
          case (step)
            6'd20: begin mul_a = jac[0]; mul_b = jac[3]; end
            6'd21: begin mul_a = jac[1]; mul_b = jac[2]; end
            6'd22: begin mul_a = jac[0]; mul_b = jac[0]; end
            6'd23: begin mul_a = jac[2]; mul_b = jac[2]; end
            6'd24: begin mul_a = jac[0]; mul_b = jac[2]; end
            6'd25: begin mul_a = jac[0]; mul_b = jac[1]; end
            6'd26: begin mul_a = jac[2]; mul_b = jac[3]; end
            6'd27: begin mul_a = jac[1]; mul_b = jac[1]; end
            6'd28: begin mul_a = jac[3]; mul_b = jac[3]; end
            6'd29: begin mul_a = jac[1]; mul_b = jac[3]; end
            6'd30: begin mul_a = a13;    mul_b = a32;    end
            6'd31: begin mul_a = a12;    mul_b = a33;    end
            6'd32: begin mul_a = a11;    mul_b = a33;    end
            6'd33: begin mul_a = a13;    mul_b = a31;    end
            6'd34: begin mul_a = a12;    mul_b = a31;    end
            6'd35: begin mul_a = a11;    mul_b = a32;    end
            6'd36: begin mul_a = a21;    mul_b = cof[0]; end
            6'd37: begin mul_a = a22;    mul_b = cof[1]; end
            6'd38: begin mul_a = a23;    mul_b = cof[2]; end
            default: begin mul_a = '0; mul_b = '0; end
          endcase
        end
      end
      ST_NODE: begin
        case (sub)
          4'd0: begin mul_a = cur.dr[k]; mul_b = inv[0];  end
          4'd1: begin mul_a = cur.ds[k]; mul_b = inv[2];  end
          4'd2: begin mul_a = cur.dr[k]; mul_b = inv[1];  end
          4'd3: begin mul_a = cur.ds[k]; mul_b = inv[3];  end
          4'd4: begin mul_a = ddx_c;     mul_b = cur.xrs; end
          4'd5: begin mul_a = ddy_c;     mul_b = cur.yrs; end
          4'd6: begin mul_a = bval;      mul_b = q[0];    end
          4'd7: begin mul_a = bval;      mul_b = q[1];    end
          4'd8: begin mul_a = bval;      mul_b = q[2];    end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider operands
  always_comb begin
    div_req.start = (state == ST_DIV) && !div_wait;
    div_req.num   = '0;
    div_req.den   = det;
    case (div_sel)
      3'd0: div_req.num = jac[3];
      3'd1: div_req.num = neg_sat(jac[1]);
      3'd2: div_req.num = neg_sat(jac[2]);
      3'd3: div_req.num = jac[0];
      3'd4: begin div_req.num = cof[0]; div_req.den = detA; end
      3'd5: begin div_req.num = cof[1]; div_req.den = detA; end
      3'd6: begin div_req.num = cof[2]; div_req.den = detA; end
      default: begin div_req.num = '0; div_req.den = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step == STEP_DET && det_cand == '0) state_next = ST_DONE;
        else if (step == STEP_LAST)             state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_wait && div_rsp.done) begin
          if (div_sel == DIV_LAST_INV && detA == '0) state_next = ST_DONE;
          else if (div_sel == DIV_LAST)              state_next = ST_NODE;
        end
      end
      ST_NODE: begin
        if (k == NODE_LAST && sub == SUB_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!ob_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      div_sel  <= '0;
      div_wait <= 1'b0;
      k        <= '0;
      sub      <= '0;
      ob_valid <= 1'b0;
      beat     <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        beat <= beat + 1'b1;
        if (beat == NODE_LAST) ob_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur      <= q_item;
            step     <= '0;
            div_sel  <= '0;
            div_wait <= 1'b0;
            k        <= '0;
            sub      <= '0;
            degen    <= 1'b0;
          end
        end
        ST_MUL: begin
          step <= step + 1'b1;
          if (step < STEP_JAC_FIRST) begin
            nval[step[1:0]] <= p;
          end else if (step <= STEP_JAC_LAST) begin
            // accumulate four rounded products per Jacobian entry
            if (jstep[1:0] == 2'd0) acc <= acc_t'(p);
            else                    acc <= acc + acc_t'(p);
            if (jstep[1:0] == 2'd3) jac[jstep[3:2]] <= sat_w(wide_t'(acc) + wide_t'(p));
          end else begin
            case (step)
              6'd20: t03 <= p;
              6'd21: begin
                det <= det_cand;
                a23 <= sat_w(wide_t'(t03) + wide_t'(p));
                if (det_cand == '0) begin
                  degen <= 1'b1;
                  inv   <= '0;
                end
              end
              6'd22: a11 <= p;
              6'd23: a12 <= p;
              6'd24: a13 <= sat_w(wide_t'(p) <<< 1);
              6'd25: a21 <= p;
              6'd26: a22 <= p;
              6'd27: a31 <= p;
              6'd28: a32 <= p;
              6'd29: a33 <= sat_w(wide_t'(p) <<< 1);
              6'd30, 6'd32, 6'd34, 6'd36: acc <= acc_t'(p);
              6'd31: cof[0] <= sat_w(wide_t'(acc) - wide_t'(p));
              6'd33: cof[1] <= sat_w(wide_t'(acc) - wide_t'(p));
              6'd35: cof[2] <= sat_w(wide_t'(acc) - wide_t'(p));
              6'd37: acc <= acc + acc_t'(p);
              6'd38: detA <= sat_w(wide_t'(acc) + wide_t'(p));
              default: acc <= acc;
            endcase
          end
        end
        ST_DIV: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
          end else if (div_rsp.done) begin
            div_wait <= 1'b0;
            div_sel  <= div_sel + 1'b1;
            case (div_sel)
              3'd0: inv[0] <= div_rsp.quo;
              3'd1: inv[1] <= div_rsp.quo;
              3'd2: inv[2] <= div_rsp.quo;
              3'd3: inv[3] <= div_rsp.quo;
              3'd4: q[0]   <= div_rsp.quo;
              3'd5: q[1]   <= div_rsp.quo;
              3'd6: q[2]   <= div_rsp.quo;
              default: q[0] <= q[0];
            endcase
            if (div_sel == DIV_LAST_INV && detA == '0) degen <= 1'b1;
          end
        end
        ST_NODE: begin
          if (sub == SUB_LAST) begin
            sub <= '0;
            k   <= k + 1'b1;
          end else begin
            sub <= sub + 1'b1;
          end
          case (sub)
            4'd0, 4'd2: acc <= acc_t'(p);
            4'd1: begin
              ddx_c  <= sat_w(wide_t'(acc) + wide_t'(p));
              ddx[k] <= sat_w(wide_t'(acc) + wide_t'(p));
            end
            4'd3: begin
              ddy_c  <= sat_w(wide_t'(acc) + wide_t'(p));
              ddy[k] <= sat_w(wide_t'(acc) + wide_t'(p));
            end
            4'd4: acc <= acc_t'(k[0] ? -FX_ONE : FX_ONE) - acc_t'(p);
            4'd5: bval <= sat_w(wide_t'(acc) - wide_t'(p));
            4'd6: dxx[k] <= p;
            4'd7: dyy[k] <= p;
            4'd8: dxy[k] <= p;
            default: acc <= acc;
          endcase
        end
        ST_DONE: begin
          if (!ob_valid) begin
            ob_valid <= 1'b1;
            beat     <= '0;
            ob.nval  <= nval;
            ob.ddx   <= degen ? '0 : ddx;
            ob.ddy   <= degen ? '0 : ddy;
            ob.dxx   <= degen ? '0 : dxx;
            ob.dyy   <= degen ? '0 : dyy;
            ob.dxy   <= degen ? '0 : dxy;
            ob.jac   <= jac;
            ob.inv   <= inv;
            ob.det   <= det;
            ob.degen <= degen;
          end
        end
        default: step <= '0;
      endcase
    end
  end

  assign m_tvalid = ob_valid;
  assign m_tlast  = (beat == NODE_LAST);
  assign m_tuser  = {ob.degen, beat};
  assign m_tdata  = {ob.det, ob.inv[beat], ob.jac[beat], ob.dxy[beat], ob.dyy[beat],
                     ob.dxx[beat], ob.ddy[beat], ob.ddx[beat], ob.nval[beat]};

  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !ob_valid) |=> ob_valid)
    else $error("result bundle not loaded");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !ob_valid)
    else $error("output buffer not freed after last transaction");

  a_node_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NODE) |-> !degen)
    else $error("derivative pass on a degenerate point");

endmodule

// ===== rtl/core/bilinear_quad_basis_eval.sv =====
// Bilinear quadrilateral shape-function evaluator. Send one transaction per
// quadrature point on the slave stream (four node coordinates and a point r,s
// in Q16.16); the master stream returns four transactions, one per node, with
// the shape value, first and second physical derivatives, one Jacobian and one
// inverse-Jacobian entry, and the determinant. tuser carries the node index
// and the degenerate flag; tlast marks the fourth transaction of a point. A
// two-deep queue holds accepted points while the back end works, and a result
// buffer holds a finished point while the next one is computed. A regular point
// takes 39 steps and 36 node steps in the back end on the one shared multiplier,
// plus seven quotients of 48 quotient bits each from the bit-serial divider. A
// point with zero determinant leaves after the determinant step, one with a
// singular 3x3 system after the four inverse-Jacobian quotients.
module bilinear_quad_basis_eval import bqbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // node_x0, node_x1, node_x2, node_x3, node_y0, node_y1, node_y2, node_y3
  // (32 each), point_r (17), point_s (17), zero pad to 296 bits
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // shape_value, shape_dx, shape_dy, shape_dxx, shape_dyy, shape_dxy,
  // jacobian_entry, inverse_jacobian_entry, jacobian_det (32 each)
  output logic [OUT_W-1:0]  m_tdata,
  // node_index (2), degenerate (1)
  output logic [USER_W-1:0] m_tuser,
  output logic              m_tlast
);

  logic     q_push, q_full, q_pop, q_valid;
  item_t    push_item, pop_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // front: unpack, clamp the point, form the parametric derivatives
  bqbe_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // queue between front and back
  bqbe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .not_empty (q_valid)
  );

  // shared quotient unit for the inverse and the 3x3 solve
  bqbe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // back: sequenced arithmetic and result buffer
  bqbe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== verif/tb_bilinear_quad_basis_eval.sv =====
`timescale 1ns / 100ps

module tb_bilinear_quad_basis_eval import bqbe_pkg::*;;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 600;
  localparam int RANDOM_POINTS   = 290;

  // One quadrature point as it travels on the slave stream
  typedef struct {
    logic signed [31:0] x[4];
    logic signed [31:0] y[4];
    logic [16:0]        r;
    logic [16:0]        s;
  } quad_point_t;

  // One node result as it travels on the master stream
  typedef struct packed {
    logic [1:0]         node;
    logic signed [31:0] nval;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dxx;
    logic signed [31:0] dyy;
    logic signed [31:0] dxy;
    logic signed [31:0] jac;
    logic signed [31:0] inv;
    logic signed [31:0] det;
    logic               degen;
    logic               last;
  } node_result_t;

  // Directed row: point plus an optional typed-in expectation for node 0
  typedef struct {
    quad_point_t  pt;
    logic         has_check;
    node_result_t node0;
  } directed_row_t;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_W-1:0]          s_tdata;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_W-1:0]         m_tdata;
  logic [USER_W-1:0]        m_tuser;
  logic                     m_tlast;

  node_result_t             shape_results_due[$];
  node_result_t             node0_typed_due[$];
  logic                     node0_typed_flag[$];
  int                       error_count = 0;
  int                       idle_cycles;
  int                       send_idle_pct;
  int                       recv_idle_pct;
  int                       points_sent;
  int                       degen_seen;
  int                       results_seen = 0;

  bilinear_quad_basis_eval dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the shape evaluator, in 64-bit signed terms
  // ---------------------------------------------------------------------------
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Exact product, round half up, saturate
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = clip32(a) * clip32(b) + (64'sd1 <<< (FRACTION_BITS - 1));
    return clip32(p >>> FRACTION_BITS);
  endfunction

  // Quotient truncated toward zero, saturate; zero divisor gives zero
  function automatic longint qdiv(longint a, longint b);
    if (b == 0) return 0;
    return clip32((clip32(a) * (64'sd1 <<< FRACTION_BITS)) / b);
  endfunction

  // Work out the four node results of one quadrature point
  task automatic predict_shape_results(input quad_point_t pt);
    longint one, r, s, omr, oms, det, xrs, yrs, det3;
    longint nv[4], dr[4], ds[4], jac[4], inv[4], ddx[4], ddy[4];
    longint d2xx[4], d2yy[4], d2xy[4], sgn[4];
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, c21, c22, c23;
    longint q1, q2, q3, rhs;
    logic degen;
    node_result_t res;
    one = 64'sd1 <<< FRACTION_BITS;
    sgn = '{1, -1, 1, -1};
    r = (pt.r > one) ? one : longint'(pt.r);
    s = (pt.s > one) ? one : longint'(pt.s);
    omr = one - r;
    oms = one - s;
    nv[0] = qmul(omr, oms);
    nv[1] = qmul(r, oms);
    nv[2] = qmul(r, s);
    nv[3] = qmul(omr, s);
    dr = '{s - one, oms, s, -s};
    ds = '{r - one, -r, r, omr};
    jac = '{0, 0, 0, 0};
    inv = '{0, 0, 0, 0};
    ddx = '{0, 0, 0, 0};
    ddy = '{0, 0, 0, 0};
    d2xx = '{0, 0, 0, 0};
    d2yy = '{0, 0, 0, 0};
    d2xy = '{0, 0, 0, 0};
    xrs = 0;
    yrs = 0;
    for (int i = 0; i < 4; i++) begin
      jac[0] += qmul(pt.x[i], dr[i]);
      jac[1] += qmul(pt.x[i], ds[i]);
      jac[2] += qmul(pt.y[i], dr[i]);
      jac[3] += qmul(pt.y[i], ds[i]);
      xrs += sgn[i] * longint'(pt.x[i]);
      yrs += sgn[i] * longint'(pt.y[i]);
    end
    for (int i = 0; i < 4; i++) jac[i] = clip32(jac[i]);
    xrs = clip32(xrs);
    yrs = clip32(yrs);
    det = clip32(qmul(jac[0], jac[3]) - qmul(jac[1], jac[2]));
    degen = 1'b0;
    if (det == 0) begin
      degen = 1'b1;
    end else begin
      inv[0] = qdiv(jac[3], det);
      inv[1] = qdiv(-jac[1], det);
      inv[2] = qdiv(-jac[2], det);
      inv[3] = qdiv(jac[0], det);
      a11 = qmul(jac[0], jac[0]);
      a12 = qmul(jac[2], jac[2]);
      a13 = clip32(2 * qmul(jac[0], jac[2]));
      a21 = qmul(jac[0], jac[1]);
      a22 = qmul(jac[2], jac[3]);
      a23 = clip32(qmul(jac[0], jac[3]) + qmul(jac[1], jac[2]));
      a31 = qmul(jac[1], jac[1]);
      a32 = qmul(jac[3], jac[3]);
      a33 = clip32(2 * qmul(jac[1], jac[3]));
      c21 = clip32(qmul(a13, a32) - qmul(a12, a33));
      c22 = clip32(qmul(a11, a33) - qmul(a13, a31));
      c23 = clip32(qmul(a12, a31) - qmul(a11, a32));
      det3 = clip32(qmul(a21, c21) + qmul(a22, c22) + qmul(a23, c23));
      if (det3 == 0) begin
        degen = 1'b1;
      end else begin
        q1 = qdiv(c21, det3);
        q2 = qdiv(c22, det3);
        q3 = qdiv(c23, det3);
        for (int i = 0; i < 4; i++) begin
          ddx[i] = clip32(qmul(dr[i], inv[0]) + qmul(ds[i], inv[2]));
          ddy[i] = clip32(qmul(dr[i], inv[1]) + qmul(ds[i], inv[3]));
          rhs = clip32(sgn[i] * one - qmul(ddx[i], xrs) - qmul(ddy[i], yrs));
          d2xx[i] = qmul(rhs, q1);
          d2yy[i] = qmul(rhs, q2);
          d2xy[i] = qmul(rhs, q3);
        end
      end
    end
    if (degen) degen_seen++;
    for (int i = 0; i < 4; i++) begin
      res.node  = 2'(i);
      res.nval  = 32'(nv[i]);
      res.dx    = degen ? '0 : 32'(ddx[i]);
      res.dy    = degen ? '0 : 32'(ddy[i]);
      res.dxx   = degen ? '0 : 32'(d2xx[i]);
      res.dyy   = degen ? '0 : 32'(d2yy[i]);
      res.dxy   = degen ? '0 : 32'(d2xy[i]);
      res.jac   = 32'(jac[i]);
      res.inv   = 32'(inv[i]);
      res.det   = 32'(det);
      res.degen = degen;
      res.last  = (i == 3);
      shape_results_due.push_back(res);
    end
  endtask

  function automatic logic [IN_W-1:0] pack_point(quad_point_t pt);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 4; i++) begin
      d[32*i +: 32]     = pt.x[i];
      d[128 + 32*i +: 32] = pt.y[i];
    end
    d[256 +: 17] = pt.r;
    d[273 +: 17] = pt.s;
    return d;
  endfunction

  // Unit square scaled by a, parametric point (r,s)
  function automatic quad_point_t square_point(longint a, logic [16:0] r, logic [16:0] s);
    quad_point_t pt;
    pt.x = '{0, 32'(a), 32'(a), 0};
    pt.y = '{0, 0, 32'(a), 32'(a)};
    pt.r = r;
    pt.s = s;
    return pt;
  endfunction

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0:       return $signed($urandom);
      1:       return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 9))
      0:       return 17'h10000;
      1:       return 17'h00000;
      2:       return 17'($urandom);
      default: return 17'($urandom_range(0, 17'h10000));
    endcase
  endfunction

  // Mostly near-regular quadrilaterals; some wild coordinates and collapsed shapes
  function automatic quad_point_t rand_point();
    quad_point_t pt;
    int kind;
    longint a;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      a = $urandom_range(32'h0000_4000, 32'h0004_0000);
      pt = square_point(a, rand_param(), rand_param());
      for (int i = 0; i < 4; i++) begin
        pt.x[i] += rand_coord(1) >>> 2;
        pt.y[i] += rand_coord(1) >>> 2;
      end
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 4; i++) begin
          pt.x[i] += rand_coord(2);
          pt.y[i] += rand_coord(2);
        end
      end
    end else if (kind < 8) begin
      for (int i = 0; i < 4; i++) begin
        pt.x[i] = rand_coord(0);
        pt.y[i] = rand_coord(0);
      end
      pt.r = rand_param();
      pt.s = rand_param();
    end else begin
      // Collapse the shape onto a line: zero determinant
      for (int i = 0; i < 4; i++) begin
        pt.x[i] = rand_coord(1);
        pt.y[i] = pt.x[i];
      end
      pt.r = rand_param();
      pt.s = rand_param();
    end
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: drive at the falling edge, hold until the transaction is accepted;
  // drop tvalid only while idling, so back-to-back points keep it high
  // ---------------------------------------------------------------------------
  task automatic send_point(input quad_point_t pt, input logic has_check,
                            input node_result_t node0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= pack_point(pt);
    s_tvalid <= 1'b1;
    predict_shape_results(pt);
    node0_typed_flag.push_back(has_check);
    node0_typed_due.push_back(node0);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    points_sent++;
    @(negedge clk);
  endtask

  // Receiver idles on its own schedule
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: compare each result transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    node_result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.node  = m_tuser[1:0];
      got.degen = m_tuser[2];
      got.last  = m_tlast;
      got.nval  = m_tdata[0 +: 32];
      got.dx    = m_tdata[32 +: 32];
      got.dy    = m_tdata[64 +: 32];
      got.dxx   = m_tdata[96 +: 32];
      got.dyy   = m_tdata[128 +: 32];
      got.dxy   = m_tdata[160 +: 32];
      got.jac   = m_tdata[192 +: 32];
      got.inv   = m_tdata[224 +: 32];
      got.det   = m_tdata[256 +: 32];
      results_seen++;
      if (shape_results_due.size() == 0) begin
        $error("unexpected result transaction for node %0d", got.node);
        error_count++;
      end else begin
        want = shape_results_due.pop_front();
        check_field("node_index", want.node, got.node);
        check_field("shape_value", want.nval, got.nval);
        check_field("shape_dx", want.dx, got.dx);
        check_field("shape_dy", want.dy, got.dy);
        check_field("shape_dxx", want.dxx, got.dxx);
        check_field("shape_dyy", want.dyy, got.dyy);
        check_field("shape_dxy", want.dxy, got.dxy);
        check_field("jacobian_entry", want.jac, got.jac);
        check_field("inverse_jacobian_entry", want.inv, got.inv);
        check_field("jacobian_det", want.det, got.det);
        check_field("degenerate", want.degen, got.degen);
        check_field("last_of_point", want.last, got.last);
        // Hand-typed node-0 values of the directed rows
        if (got.node == 2'd0 && node0_typed_flag.size() > 0) begin
          if (node0_typed_flag.pop_front()) begin
            want = node0_typed_due.pop_front();
            check_field("typed shape_value", want.nval, got.nval);
            check_field("typed jacobian_entry", want.jac, got.jac);
            check_field("typed inverse_jacobian_entry", want.inv, got.inv);
            check_field("typed jacobian_det", want.det, got.det);
            check_field("typed degenerate", want.degen, got.degen);
          end else begin
            void'(node0_typed_due.pop_front());
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog expired with %0d results outstanding", shape_results_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic node_result_t typed_node0(longint nval, longint jac, longint inv,
                                               longint det, logic degen);
    node_result_t t;
    t = '0;
    t.nval  = 32'(nval);
    t.jac   = 32'(jac);
    t.inv   = 32'(inv);
    t.det   = 32'(det);
    t.degen = degen;
    return t;
  endfunction

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    quad_point_t pt;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    points_sent = 0;
    degen_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Unit square at the corners: N0 = 1 at r=s=0; Jacobian identity, det one
    row.has_check = 1'b1;
    row.pt = square_point(32'h10000, 17'd0, 17'd0);
    row.node0 = typed_node0(32'h10000, 32'h10000, 32'h10000, 32'h10000, 1'b0);
    rows.push_back(row);
    row.pt = square_point(32'h10000, 17'h10000, 17'h10000);
    row.node0 = typed_node0(0, 32'h10000, 32'h10000, 32'h10000, 1'b0);
    rows.push_back(row);
    // Parameter above one clamps to one
    row.pt = square_point(32'h10000, 17'h1FFFF, 17'h1FFFF);
    rows.push_back(row);
    // Square of side two: Jacobian two, det four, inverse one half
    row.pt = square_point(32'h20000, 17'd0, 17'd0);
    row.node0 = typed_node0(32'h10000, 32'h20000, 32'h8000, 32'h40000, 1'b0);
    rows.push_back(row);
    // All nodes at one place: zero determinant, derivatives zero
    row.pt = square_point(0, 17'h8000, 17'h8000);
    row.node0 = typed_node0(32'h4000, 0, 0, 0, 1'b1);
    rows.push_back(row);
    row.has_check = 1'b0;
    // Collapsed onto a line
    row.pt.x = '{0, 32'h10000, 32'h10000, 0};
    row.pt.y = '{0, 32'h10000, 32'h10000, 0};
    rows.push_back(row);
    // Tiny squares: nonzero det with a 3x3 system rounding to zero; then det zero
    row.pt = square_point(32'h100, 17'h8000, 17'h4000);
    rows.push_back(row);
    row.pt = square_point(32'h40, 17'h1, 17'hFFFF);
    rows.push_back(row);
    // Coordinate extremes, saturating paths
    row.pt.x = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
    row.pt.y = '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF};
    row.pt.r = 17'h10000;
    row.pt.s = 17'd0;
    rows.push_back(row);
    row.pt.x = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF};
    row.pt.y = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    row.pt.r = 17'h8000;
    row.pt.s = 17'h8000;
    rows.push_back(row);
    row.pt.x = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
    row.pt.y = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    rows.push_back(row);
    // Skewed and mirrored quadrilaterals
    row.pt.x = '{0, 32'h30000, 32'h50000, 32'h18000};
    row.pt.y = '{0, 32'h08000, 32'h40000, 32'h30000};
    row.pt.r = 17'h5555;
    row.pt.s = 17'hAAAA;
    rows.push_back(row);
    row.pt.x = '{0, -32'sh10000, -32'sh10000, 0};
    row.pt.y = '{0, 0, 32'h10000, 32'h10000};
    row.pt.r = 17'h2000;
    row.pt.s = 17'hE000;
    rows.push_back(row);
    row.pt.x = '{32'h0FFFFFFF, 32'h1FFFFFFF, 32'h1FFFFFFF, 32'h0FFFFFFF};
    row.pt.y = '{-32'sh1000, -32'sh1000, 32'h7FFFFFFF, 32'h7FFFFFFF};
    row.pt.r = 17'h18000;
    row.pt.s = 17'h0FFFF;
    rows.push_back(row);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_point(rows[i].pt, rows[i].has_check, rows[i].node0);
    s_tvalid <= 1'b0;

    // Hold the sender until the block has drained
    while (shape_results_due.size() != 0) @(negedge clk);

    node0_typed_flag.delete();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 33 : 0;
      for (int n = 0; n < RANDOM_POINTS / 3; n++) begin
        pt = rand_point();
        send_point(pt, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (shape_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d points, %0d node results, %0d degenerate points",
             points_sent, results_seen, degen_seen);
    $display("under three sender/receiver idle mixes, with a full drain pause");
    if (error_count == 0 && shape_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bqbe_pkg.sv
rtl/core/bqbe_front.sv
rtl/core/bqbe_fifo.sv
rtl/core/bqbe_div.sv
rtl/core/bqbe_back.sv
rtl/core/bilinear_quad_basis_eval.sv
verif/tb_bilinear_quad_basis_eval.sv
